// ----- sv/itoa_pkg.sv -----
// itoa_pkg: shared constants and controller/datapath interface types for the itoa core
package itoa_pkg;

    localparam logic [7:0] CHAR_ZERO     = 8'd48;
    localparam logic [7:0] CHAR_MINUS    = 8'd45;
    localparam int         BITS_PER_STEP = 4;
    localparam int         BCD_BITS      = 4;

    typedef struct packed {
        logic load;
        logic convert;
        logic align;
        logic emit;
    } itoa_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic last_char;
        logic out_free;
    } itoa_status_t;

endpackage

// ----- sv/itoa_ctrl.sv -----
// itoa_ctrl: sequencer for load, conversion, alignment and character output
module itoa_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  itoa_pkg::itoa_status_t status,
    output itoa_pkg::itoa_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.convert = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_char)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/itoa_dpath.sv -----
// itoa_dpath: magnitude, shift-add-3 bcd conversion, digit pointer and output register
module itoa_dpath
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [DATA_WIDTH-1:0]  value,
    input  itoa_pkg::itoa_cmd_t    cmd,
    output itoa_pkg::itoa_status_t status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             character,
    output logic                   last
);

    localparam int NDIG  = (DATA_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * itoa_pkg::BCD_BITS;
    localparam int STEPS = (DATA_WIDTH + itoa_pkg::BITS_PER_STEP - 1) / itoa_pkg::BITS_PER_STEP;
    localparam int PAD_W = STEPS * itoa_pkg::BITS_PER_STEP;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int IDX_W = $clog2(NDIG);

    logic [PAD_W-1:0]      bin_reg;
    logic [PAD_W-1:0]      bin_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            character_reg;
    logic [7:0]            character_next;
    logic                  last_reg;
    logic                  last_next;

    logic [DATA_WIDTH-1:0] mag;
    logic [BCD_W-1:0]      bcd_step;
    logic [PAD_W-1:0]      bin_step;
    logic [IDX_W-1:0]      top_pos;
    logic [3:0]            cur_digit;

    assign mag = value[DATA_WIDTH-1] ? (~value + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : value;

    // shift-add-3 over several bits per cycle
    always_comb
    begin
        bcd_step = bcd_reg;
        bin_step = bin_reg;
        for (int s = 0; s < itoa_pkg::BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (bcd_step[d*4 +: 4] >= 4'd5)
                begin
                    bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], bin_step[PAD_W-1]};
            bin_step = {bin_step[PAD_W-2:0], 1'b0};
        end
    end

    // most significant nonzero digit, zero maps to position 0
    always_comb
    begin
        top_pos = '0;
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                top_pos = IDX_W'(d);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        character_next = character_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            bin_next = PAD_W'(mag);
            bcd_next = '0;
            cnt_next = CNT_W'(STEPS);
            neg_next = value[DATA_WIDTH-1];
        end

        if (cmd.convert)
        begin
            bin_next = bin_step;
            bcd_next = bcd_step;
            cnt_next = cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};
        end

        if (cmd.align)
        begin
            idx_next = top_pos;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (neg_reg)
            begin
                character_next = itoa_pkg::CHAR_MINUS;
                last_next      = 1'b0;
                neg_next       = 1'b0;
            end
            else
            begin
                character_next = itoa_pkg::CHAR_ZERO + {4'd0, cur_digit};
                last_next      = (idx_reg == '0);
                idx_next       = idx_reg - {{(IDX_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        neg_reg       <= neg_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign status.conv_done = (cnt_reg == {{(CNT_W-1){1'b0}}, 1'b1});
    assign status.last_char = !neg_reg && (idx_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

endmodule

// ----- sv/signed_int_to_decimal_ascii_core.sv -----
// signed_int_to_decimal_ascii_core: signed integer to decimal ascii text, top level
//
// input channel: value with in_valid/in_ready, one signed two's-complement integer per beat
// output channel: character and last with out_valid/out_ready, one ascii character per beat
// text comes out most significant first, '-' leads a negative value, no leading zeros,
// zero gives a single '0', last marks the final character of each number
// one number is worked at a time; in_ready is high only while the block is idle
// after a beat is taken, conversion runs on the shift-add-3 datapath (four bits per cycle),
// then the align state picks the leading digit
// characters then leave at one per cycle from the output register while the receiver
// takes each one; at 32 bits a number is up to 11 characters long
// a stalled receiver holds the current character in the output register and the
// sequencer waits; the next number is taken while the final character still waits
// reset clears the sequencer and the output valid, no clearing pass is needed
module signed_int_to_decimal_ascii_core
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            character,
    output logic                  last
);

    itoa_pkg::itoa_cmd_t    cmd;
    itoa_pkg::itoa_status_t status;

    itoa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    itoa_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule
